// ===== rtl/core/gprd_pkg.sv =====
package gprd_pkg;

  localparam int FULL_SCALE = 32767;

  localparam int DZ_W       = 15;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [DZ_W-1:0]  LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0]  RIGHT_DZ_RST = 15'd8689;
  localparam logic [THR_W-1:0] TRIG_THR_RST = 8'd30;

  localparam int GPRD_QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_DZ  = 2'd0,
    CFG_RIGHT_DZ = 2'd1,
    CFG_TRIG_THR = 2'd2
  } gprd_cfg_idx_t;

  typedef struct packed {
    logic [DZ_W-1:0]  left_dz;
    logic [DZ_W-1:0]  right_dz;
    logic [THR_W-1:0] thr;
  } gprd_cfg_t;

  typedef struct packed {
    logic [15:0]        buttons_in;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } gprd_in_t;

  typedef struct packed {
    logic [15:0]        buttons_out;
    logic signed [15:0] left_norm_x;
    logic signed [15:0] left_norm_y;
    logic signed [15:0] right_norm_x;
    logic signed [15:0] right_norm_y;
    logic               left_trigger_on;
    logic               right_trigger_on;
  } gprd_out_t;

  // one stick after classification: sign, magnitude per axis, squared radius
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [31:0] sq;
  } gprd_stick_in_t;

  typedef struct packed {
    logic [15:0]    buttons;
    logic           lt_on;
    logic           rt_on;
    gprd_stick_in_t lstick;
    gprd_stick_in_t rstick;
  } gprd_work_t;

endpackage

// ===== rtl/core/gprd_stream_if.sv =====
interface gprd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gprd_front.sv =====
module gprd_front import gprd_pkg::*; (
  input  logic [THR_W-1:0] thr,
  gprd_stream_if.sink      in_ch,
  output logic             wr_valid,
  input  logic             wr_ready,
  output gprd_work_t       wr_data
);

  function automatic gprd_stick_in_t classify(logic signed [15:0] x, logic signed [15:0] y);
    gprd_stick_in_t st;
    logic [15:0] mx, my;
    mx = x[15] ? 16'(-x) : 16'(x);
    my = y[15] ? 16'(-y) : 16'(y);
    st.neg_x = x[15];
    st.neg_y = y[15];
    st.mag_x = mx;
    st.mag_y = my;
    st.sq    = ({16'b0, mx} * {16'b0, mx}) + ({16'b0, my} * {16'b0, my});
    return st;
  endfunction

  assign wr_valid    = in_ch.valid;
  assign in_ch.ready = wr_ready;

  always_comb begin
    wr_data.buttons = in_ch.data.buttons_in;
    wr_data.lt_on   = in_ch.data.left_trigger > thr;
    wr_data.rt_on   = in_ch.data.right_trigger > thr;
    wr_data.lstick  = classify(in_ch.data.left_x, in_ch.data.left_y);
    wr_data.rstick  = classify(in_ch.data.right_x, in_ch.data.right_y);
  end

endmodule

// ===== rtl/core/gprd_queue.sv =====
module gprd_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  T     wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output T     rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           wr, rd;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  assign wp_nxt  = wr ? bump(wp_r) : wp_r;
  assign rp_nxt  = rd ? bump(rp_r) : rp_r;
  assign cnt_nxt = cnt_r + CW'(wr) - CW'(rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/gprd_back.sv =====
module gprd_back import gprd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gprd_cfg_t   cfg,
  input  logic        rd_valid,
  output logic        rd_ready,
  input  gprd_work_t  rd_data,
  gprd_stream_if.source out_ch
);

  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 26;
  localparam int SPAN_W     = 23;
  localparam int PROD_W     = 39;
  localparam int NUM_W      = 56;
  localparam int DEN_W      = 40;
  localparam int QW         = 16;
  localparam int ROOT_ITERS = ROOT_W / 2;
  localparam int DIV_ITERS  = QW;
  localparam int CNT_W      = $clog2(DIV_ITERS);
  localparam logic [ROOT_W-1:0] CLIP = ROOT_W'(FULL_SCALE * 256);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } gprd_root_t;

  typedef enum logic [2:0] {S1_IDLE, S1_ROOT, S1_SCALE, S1_PREP, S1_HOLD} s1_state_t;
  typedef enum logic [1:0] {S2_IDLE, S2_DIV, S2_DONE} s2_state_t;

  // one digit of the square root per call
  function automatic gprd_root_t root_step(gprd_root_t st, logic [1:0] pair);
    logic [REM_W+1:0] acc, trial;
    gprd_root_t nx;
    acc   = {st.rem, pair};
    trial = {2'b00, st.root, 2'b01};
    if (acc >= trial) begin
      nx.rem  = REM_W'(acc - trial);
      nx.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      nx.rem  = acc[REM_W-1:0];
      nx.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return nx;
  endfunction

  s1_state_t          s1_state_r;
  s2_state_t          s2_state_r;
  gprd_work_t         s1_work_r;
  gprd_stick_in_t     stk [2];
  logic [DZ_W-1:0]    dz [2];
  logic [2*DZ_W-1:0]  dd_r [2];
  gprd_root_t         root_r [2], root_nxt [2];
  logic [RAD_W-1:0]   rad_r [2];
  logic [CNT_W-1:0]   cnt1_r, cnt2_r;
  logic [PROD_W-1:0]  px_r [2], py_r [2], den_r [2];
  logic [PROD_W-1:0]  px_nxt [2], py_nxt [2], den_nxt [2];
  logic               live_r [2], live_nxt [2];
  logic [NUM_W-1:0]   hn_r [4], hn_nxt [4];
  logic [DEN_W-1:0]   hd_r [2], hd_nxt [2];
  logic               hzero_r [2], hzero_nxt [2];
  logic               neg1 [4];

  logic [15:0]        btn2_r;
  logic               lt2_r, rt2_r;
  logic               neg2_r [4], zero2_r [4], ovf2_r [4];
  logic [NUM_W-1:0]   rem2_r [4];
  logic [NUM_W-2:0]   dsh2_r [4];
  logic [QW-1:0]      q2_r [4];
  logic [15:0]        val [4];

  logic               xfer, out_load, out_valid_r;
  gprd_out_t          out_nxt, out_data_r;

  assign stk[0] = s1_work_r.lstick;
  assign stk[1] = s1_work_r.rstick;
  assign dz[0]  = cfg.left_dz;
  assign dz[1]  = cfg.right_dz;
  assign neg1[0] = stk[0].neg_x;
  assign neg1[1] = stk[0].neg_y;
  assign neg1[2] = stk[1].neg_x;
  assign neg1[3] = stk[1].neg_y;

  assign rd_ready = s1_state_r == S1_IDLE;
  assign xfer     = (s1_state_r == S1_HOLD) && (s2_state_r == S2_IDLE);
  assign out_load = (s2_state_r == S2_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      dd_r[k] <= dz[k] * dz[k];
    end
  end

  always_comb begin
    logic [ROOT_W-1:0] r, clip;
    logic [SPAN_W-1:0] dz8, span;
    logic [DZ_W-1:0]   dspan;
    for (int k = 0; k < 2; k++) begin
      root_nxt[k] = root_step(root_step(root_r[k], rad_r[k][RAD_W-1 -: 2]),
                              rad_r[k][RAD_W-3 -: 2]);
      r     = root_r[k].root;
      clip  = (r > CLIP) ? CLIP : r;
      dz8   = {dz[k], 8'b0};
      span  = (clip > {1'b0, dz8}) ? SPAN_W'(clip - {1'b0, dz8}) : '0;
      dspan = DZ_W'(FULL_SCALE) - dz[k];
      px_nxt[k]   = stk[k].mag_x * span;
      py_nxt[k]   = stk[k].mag_y * span;
      den_nxt[k]  = r * dspan;
      live_nxt[k] = stk[k].sq > {2'b00, dd_r[k]};
      // numerator doubled for round-half-up: p*65534 + den
      hn_nxt[2*k]   = NUM_W'({px_r[k], 16'b0}) - NUM_W'({px_r[k], 1'b0})
                      + NUM_W'(den_r[k]);
      hn_nxt[2*k+1] = NUM_W'({py_r[k], 16'b0}) - NUM_W'({py_r[k], 1'b0})
                      + NUM_W'(den_r[k]);
      hd_nxt[k]     = {den_r[k], 1'b0};
      hzero_nxt[k]  = !live_r[k] || (den_r[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_state_r <= S1_IDLE;
    end else begin
      case (s1_state_r)
        S1_IDLE: begin
          if (rd_valid) begin
            s1_work_r <= rd_data;
            root_r[0] <= '0;
            root_r[1] <= '0;
            rad_r[0]  <= {rd_data.lstick.sq, 16'b0};
            rad_r[1]  <= {rd_data.rstick.sq, 16'b0};
            cnt1_r    <= '0;
            s1_state_r <= S1_ROOT;
          end
        end
        S1_ROOT: begin
          for (int k = 0; k < 2; k++) begin
            root_r[k] <= root_nxt[k];
            rad_r[k]  <= rad_r[k] << 4;
          end
          cnt1_r <= cnt1_r + 1'b1;
          if (cnt1_r == CNT_W'(ROOT_ITERS - 1)) begin
            s1_state_r <= S1_SCALE;
          end
        end
        S1_SCALE: begin
          for (int k = 0; k < 2; k++) begin
            px_r[k]   <= px_nxt[k];
            py_r[k]   <= py_nxt[k];
            den_r[k]  <= den_nxt[k];
            live_r[k] <= live_nxt[k];
          end
          s1_state_r <= S1_PREP;
        end
        S1_PREP: begin
          for (int a = 0; a < 4; a++) begin
            hn_r[a] <= hn_nxt[a];
          end
          for (int k = 0; k < 2; k++) begin
            hd_r[k]    <= hd_nxt[k];
            hzero_r[k] <= hzero_nxt[k];
          end
          s1_state_r <= S1_HOLD;
        end
        S1_HOLD: begin
          if (s2_state_r == S2_IDLE) begin
            s1_state_r <= S1_IDLE;
          end
        end
        default: s1_state_r <= S1_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_state_r <= S2_IDLE;
    end else begin
      case (s2_state_r)
        S2_IDLE: begin
          if (xfer) begin
            btn2_r <= s1_work_r.buttons;
            lt2_r  <= s1_work_r.lt_on;
            rt2_r  <= s1_work_r.rt_on;
            for (int a = 0; a < 4; a++) begin
              rem2_r[a]  <= hn_r[a];
              dsh2_r[a]  <= {hd_r[a>>1], 15'b0};
              ovf2_r[a]  <= hn_r[a] >= {hd_r[a>>1], 16'b0};
              neg2_r[a]  <= neg1[a];
              zero2_r[a] <= hzero_r[a>>1];
              q2_r[a]    <= '0;
            end
            cnt2_r     <= '0;
            s2_state_r <= S2_DIV;
          end
        end
        S2_DIV: begin
          // restoring divide, one quotient bit per axis per cycle
          for (int a = 0; a < 4; a++) begin
            if (rem2_r[a] >= {1'b0, dsh2_r[a]}) begin
              rem2_r[a] <= rem2_r[a] - {1'b0, dsh2_r[a]};
              q2_r[a]   <= {q2_r[a][QW-2:0], 1'b1};
            end else begin
              q2_r[a]   <= {q2_r[a][QW-2:0], 1'b0};
            end
            dsh2_r[a] <= dsh2_r[a] >> 1;
          end
          cnt2_r <= cnt2_r + 1'b1;
          if (cnt2_r == CNT_W'(DIV_ITERS - 1)) begin
            s2_state_r <= S2_DONE;
          end
        end
        S2_DONE: begin
          if (out_load) begin
            s2_state_r <= S2_IDLE;
          end
        end
        default: s2_state_r <= S2_IDLE;
      endcase
    end
  end

  always_comb begin
    logic [QW-1:0] m;
    for (int a = 0; a < 4; a++) begin
      m = (ovf2_r[a] || q2_r[a][QW-1]) ? QW'(FULL_SCALE) : q2_r[a];
      if (zero2_r[a]) begin
        m = '0;
      end
      val[a] = neg2_r[a] ? 16'(-m) : m;
    end
    out_nxt.buttons_out      = btn2_r;
    out_nxt.left_norm_x      = val[0];
    out_nxt.left_norm_y      = val[1];
    out_nxt.right_norm_x     = val[2];
    out_nxt.right_norm_y     = val[3];
    out_nxt.left_trigger_on  = lt2_r;
    out_nxt.right_trigger_on = rt2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== rtl/core/gamepad_radial_deadzone_unit.sv =====
// radial thumbstick deadzone for gamepad reports
// in_ch carries one report per beat (buttons, two sticks, two triggers),
// out_ch one result per report, in order; both are valid/ready streams.
// cfg_we/cfg_index/cfg_data write the left and right deadzone radii and the
// shared trigger threshold; write them only while no report is in flight.
// a front stage classifies each report (axis signs and magnitudes, squared
// radius, trigger flags) into a small queue, so in_ch keeps taking beats while
// the back end is busy.
// the back end runs two overlapped stages: a square root at two bits a cycle
// plus the scale products, then a restoring divider for all four axes at one
// quotient bit a cycle. the first stage takes the next report while the
// divider works on the last, and the sustained rate is set by the divider.
// a stalled out_ch holds its beat in the output register; the divider and the
// queue fill behind it and in_ready drops once the queue is full.
// reset empties the queue and all stages and restores the register defaults.
module gamepad_radial_deadzone_unit import gprd_pkg::*; #(
  parameter int QUEUE_DEPTH = GPRD_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gprd_stream_if.sink           in_ch,
  gprd_stream_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  gprd_cfg_t  cfg_r;
  logic       wr_valid, wr_ready, rd_valid, rd_ready;
  gprd_work_t wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_dz  <= LEFT_DZ_RST;
      cfg_r.right_dz <= RIGHT_DZ_RST;
      cfg_r.thr      <= TRIG_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_DZ:  cfg_r.left_dz  <= cfg_data[DZ_W-1:0];
        CFG_RIGHT_DZ: cfg_r.right_dz <= cfg_data[DZ_W-1:0];
        CFG_TRIG_THR: cfg_r.thr      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  gprd_front u_front (
    .thr      (cfg_r.thr),
    .in_ch    (in_ch),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  gprd_queue #(
    .T     (gprd_work_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  gprd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/core/gprd_checker.sv =====
module gprd_checker import gprd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input gprd_out_t out_data
);

  logic [7:0] pending_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 8'(in_beat) - 8'(out_beat);
    end
  end

  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 8'd0)
    else $error("result beat without a report");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && pending_r == 8'd0 |=> !out_valid)
    else $error("result too early");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 8'd0 |-> in_ready)
    else $error("input stalled while empty");

endmodule

bind gamepad_radial_deadzone_unit gprd_checker u_gprd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import gprd_pkg::*;

  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gprd_stream_if #(.T(gprd_in_t)) in_ch ();
  gprd_stream_if #(.T(gprd_out_t)) out_ch ();

  gamepad_radial_deadzone_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  logic [14:0] left_dz;
  logic [14:0] right_dz;
  logic [7:0] trig_thr;
  gprd_out_t expected_reports[$];
  int fail_count = 0;
  bit sink_hold = 1'b0;
  bit quiet_idle = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [15:0] rescale_axis(logic signed [15:0] a, longint unsigned span,
                                               longint unsigned den);
    longint unsigned mag, q;
    logic [15:0] qv;
    if (den == 0) return 16'd0;
    mag = (a < 0) ? longint'(-int'(a)) : longint'(a);
    q = (2 * mag * span * FULL_SCALE + den) / (2 * den);
    if (q > FULL_SCALE) q = FULL_SCALE;
    qv = q[15:0];
    return (a < 0) ? -qv : qv;
  endfunction

  function automatic void predict_stick(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic [14:0] dz, output logic [15:0] ox,
                                        output logic [15:0] oy);
    longint unsigned sq, n, r, bitv, c, d, span;
    d = dz;
    sq = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y));
    ox = 16'd0;
    oy = 16'd0;
    if (sq > d * d) begin
      // integer square root of sq*65536
      n = sq << 16;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      c = (r > FULL_SCALE * 256) ? FULL_SCALE * 256 : r;
      span = (c > d * 256) ? c - d * 256 : 0;
      ox = rescale_axis(x, span, r * (FULL_SCALE - d));
      oy = rescale_axis(y, span, r * (FULL_SCALE - d));
    end
  endfunction

  function automatic gprd_out_t predict_report(gprd_in_t rep);
    gprd_out_t res;
    res.buttons_out = rep.buttons_in;
    predict_stick(rep.left_x, rep.left_y, left_dz, res.left_norm_x, res.left_norm_y);
    predict_stick(rep.right_x, rep.right_y, right_dz, res.right_norm_x, res.right_norm_y);
    res.left_trigger_on = rep.left_trigger > trig_thr;
    res.right_trigger_on = rep.right_trigger > trig_thr;
    return res;
  endfunction

  task automatic write_reg(input gprd_cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEFT_DZ: left_dz = value[14:0];
      CFG_RIGHT_DZ: right_dz = value[14:0];
      default: trig_thr = value[7:0];
    endcase
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input int ldz, input int rdz, input int thr);
    wait_drained();
    write_reg(CFG_LEFT_DZ, ldz);
    write_reg(CFG_RIGHT_DZ, rdz);
    write_reg(CFG_TRIG_THR, thr);
  endtask

  // called just after a negedge; returns after the negedge following acceptance
  // with valid still high, so the next beat can follow with no gap
  task automatic send_report(input gprd_in_t rep);
    while (!quiet_idle && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= rep;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_reports.push_back(predict_report(rep));
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic gprd_in_t rand_report();
    gprd_in_t rep;
    rep.buttons_in = 16'($urandom);
    rep.left_x = rand_axis();
    rep.left_y = rand_axis();
    rep.right_x = rand_axis();
    rep.right_y = rand_axis();
    rep.left_trigger = 8'($urandom);
    rep.right_trigger = 8'($urandom);
    return rep;
  endfunction

  function automatic gprd_in_t make_report(logic [15:0] b, int lx, int ly, int rx, int ry,
                                           int lt, int rt);
    gprd_in_t rep;
    rep = '{b, 16'(lx), 16'(ly), 16'(rx), 16'(ry), 8'(lt), 8'(rt)};
    return rep;
  endfunction

  task automatic test_directed();
    send_report(make_report(16'h0000, 0, 0, 0, 0, 0, 0));
    send_report(make_report(16'hffff, 32767, 32767, -32768, -32768, 255, 255));
    send_report(make_report(16'ha5a5, 7849, 0, 0, 8689, 30, 31));
    send_report(make_report(16'h5a5a, 7850, 0, 0, -8690, 31, 30));
    send_report(make_report(16'h0001, -32768, 0, 0, 32767, 29, 200));
    send_report(make_report(16'h8000, 23170, 23170, -23170, 23171, 100, 0));
    send_report(make_report(16'h1234, 1000, -1000, 5000, 6000, 1, 254));
    send_report(make_report(16'h4321, 32767, 1, 1, -32768, 128, 127));
    set_config(0, 0, 0);
    send_report(make_report(16'h00ff, 1, 0, 0, -1, 0, 1));
    send_report(make_report(16'hff00, -32768, -32768, 32767, -32768, 1, 0));
    send_report(make_report(16'h0f0f, 12345, -321, -1, 1, 2, 3));
    set_config(32767, 32767, 255);
    send_report(make_report(16'hf0f0, 32767, 32767, -32768, -32768, 255, 255));
    send_report(make_report(16'h3333, -32768, 0, 32767, 0, 254, 0));
    send_report(make_report(16'hcccc, 100, 100, 20000, 20000, 0, 255));
    set_config(32766, 1, 128);
    send_report(make_report(16'h7777, 32767, 32767, 1, 1, 128, 129));
    send_report(make_report(16'h8888, -32768, 10, 2, 0, 129, 128));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_report(rand_report());
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    quiet_idle = 1'b1;
    repeat (12) send_report(rand_report());
    quiet_idle = 1'b0;
  endtask

  always begin
    @(negedge clk);
    out_ch.ready <= !sink_hold && !(!quiet_idle && $urandom_range(99) < 8);
  end

  // long hold-off on the result side, counted here
  always begin
    @(posedge sink_hold);
    repeat (300) @(negedge clk);
    sink_hold = 1'b0;
  end

  always @(posedge clk) begin
    gprd_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected result: actual %h", $realtime, out_ch.data);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t mismatch: expected %h actual %h", $realtime, want, out_ch.data);
          fail_count++;
        end
      end
    end
  end

  initial begin
    left_dz = LEFT_DZ_RST;
    right_dz = RIGHT_DZ_RST;
    trig_thr = TRIG_THR_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    set_config(LEFT_DZ_RST, RIGHT_DZ_RST, TRIG_THR_RST);
    test_random(200);
    test_backpressure();
    set_config($urandom_range(32767), $urandom_range(32767), $urandom_range(255));
    test_random(150);
    quiet_idle = 1'b1;
    test_random(150);
    quiet_idle = 1'b0;
    set_config($urandom_range(2000), $urandom_range(30000, 32767), $urandom_range(255));
    test_random(230);
    wait_drained();
    if (fail_count == 0) begin
      $display("gamepad_radial_deadzone_unit verification clean");
    end else begin
      $display("gamepad_radial_deadzone_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("gamepad_radial_deadzone_unit verification failed");
    $finish;
  end

endmodule
